>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL files; the timer queue core uses them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted
`define ASSERT_DIS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check, active in and out of reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Constants and codes for the deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

    // Microsecond arithmetic
    localparam logic [20:0] USEC_PER_SEC = 21'd1000000;
    localparam logic [19:0] USEC_MAX     = 20'd999999;

    // Fired words per run item and the counter that holds that count
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

    // Operation codes
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_RUN = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_FIRED    = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

endpackage

`default_nettype wire

>>> sv/dtq_ram.sv
// ----------------------------------------------------------------------------
// dtq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/deadline_timer_queue_core.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_core
// Store of pending timers with add and earliest-first expiry.
// ----------------------------------------------------------------------------
// An add word's free-slot search walks the valid bits one per cycle, then
// the entry is written and answered. A run word rescans the timer RAM once
// per fired timer through one shared ordering comparator, one entry per
// cycle behind the registered RAM read, plus a final scan that finds nothing
// due unless the cap of 16 fired words per run is reached. The block takes a
// new word only when idle; a result word waits in the output register. No
// clearing pass after reset: entries are tracked by flip-flop valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module deadline_timer_queue_core #(
    parameter int CAPACITY = 16,
    parameter int ID_BITS  = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // item channel
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic               operation,
    input  wire logic [31:0]        now_seconds,
    input  wire logic [19:0]        now_microseconds,
    input  wire logic signed [31:0] add_seconds,
    input  wire logic signed [31:0] add_microseconds,
    input  wire logic [ID_BITS-1:0] timer_id,
    input  wire logic               periodic,
    // result channel
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic [1:0]              result_kind,
    output logic [ID_BITS-1:0]      fired_id,
    output logic                    last
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ADD_SCAN = 3'd1;
    localparam logic [2:0] ST_ADD_RESP = 3'd2;
    localparam logic [2:0] ST_SCAN     = 3'd3;
    localparam logic [2:0] ST_CHECK    = 3'd4;
    localparam logic [2:0] ST_FIRE     = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    typedef struct packed {
        logic [31:0]        dl_sec;
        logic [19:0]        dl_usec;
        logic [31:0]        per_sec;
        logic [19:0]        per_usec;
        logic [ID_BITS-1:0] id;
        logic               periodic;
        logic [31:0]        order;
    } entry_t;

    // control state
    logic [2:0]                        state_reg, state_next;
    logic [CAPACITY-1:0]               valid_reg, valid_next;
    logic [31:0]                       insert_cnt_reg, insert_cnt_next;
    logic [IDX_W-1:0]                  slot_reg, slot_next;
    logic [CNT_W-1:0]                  scan_cnt_reg, scan_cnt_next;
    logic                              rd_vld_reg, rd_vld_next;
    logic                              best_found_reg, best_found_next;
    logic                              pend_reg, pend_next;
    logic [dtq_pkg::FIRE_CNT_W-1:0]    fire_cnt_reg, fire_cnt_next;
    logic                              result_valid_reg, result_valid_next;

    // payload
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    entry_t             best_reg, best_next;
    logic [ID_BITS-1:0] pend_id_reg, pend_id_next;
    logic [1:0]         resp_kind_reg, resp_kind_next;
    logic [1:0]         result_kind_reg, result_kind_next;
    logic [ID_BITS-1:0] fired_id_reg, fired_id_next;
    logic               last_reg, last_next;
    logic               op_reg;
    logic [31:0]        now_s_reg;
    logic [19:0]        now_us_reg;
    logic [31:0]        add_s_reg;
    logic [19:0]        add_us_reg;
    logic [ID_BITS-1:0] id_reg;
    logic               periodic_reg;

    // RAM port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    entry_t             ram_rdata;

    // shared datapath
    logic               item_acc;
    logic               out_free;
    logic [31:0]        arm_per_s;
    logic [19:0]        arm_per_u;
    logic [20:0]        arm_usum;
    logic               arm_carry;
    logic [31:0]        arm_sec;
    logic [19:0]        arm_usec;
    logic [31:0]        cmp_ds;
    logic [31:0]        cmp_dord;
    logic               cmp_before;
    logic               exp_borrow;
    logic [31:0]        exp_ds;
    logic [21:0]        exp_du;
    logic               expired;
    logic               clamp_us;
    logic               clamp_s;

    assign item_acc   = item_valid && item_ready;
    assign out_free   = !result_valid_reg || result_ready;
    assign item_ready = (state_reg == ST_IDLE);

    // interval clamp at capture
    assign clamp_us = add_microseconds[31]
                      || ($unsigned(add_microseconds) >= {11'd0, dtq_pkg::USEC_PER_SEC});
    assign clamp_s  = add_seconds[31];

    // arm unit: deadline = now + period with microsecond carry
    assign arm_per_s = (state_reg == ST_ADD_SCAN) ? add_s_reg  : best_reg.per_sec;
    assign arm_per_u = (state_reg == ST_ADD_SCAN) ? add_us_reg : best_reg.per_usec;
    assign arm_usum  = {1'b0, now_us_reg} + {1'b0, arm_per_u};
    assign arm_carry = (arm_usum >= dtq_pkg::USEC_PER_SEC);
    assign arm_usec  = arm_carry ? 20'(arm_usum - dtq_pkg::USEC_PER_SEC) : arm_usum[19:0];
    assign arm_sec   = now_s_reg + arm_per_s + {31'd0, arm_carry};

    // ordering comparator: RAM word against the best so far
    assign cmp_ds   = ram_rdata.dl_sec - best_reg.dl_sec;
    assign cmp_dord = ram_rdata.order - best_reg.order;
    always_comb
    begin
        if (cmp_ds != 32'd0)
        begin
            cmp_before = cmp_ds[31];
        end
        else if (ram_rdata.dl_usec != best_reg.dl_usec)
        begin
            cmp_before = (ram_rdata.dl_usec < best_reg.dl_usec);
        end
        else
        begin
            cmp_before = cmp_dord[31];
        end
    end

    // expiry test: deadline strictly before now
    assign exp_borrow = (now_us_reg < best_reg.dl_usec);
    assign exp_ds     = now_s_reg - best_reg.dl_sec - {31'd0, exp_borrow};
    assign exp_du     = {2'd0, now_us_reg} - {2'd0, best_reg.dl_usec}
                        + (exp_borrow ? {1'b0, dtq_pkg::USEC_PER_SEC} : 22'd0);
    assign expired    = (exp_ds != 32'd0) ? !exp_ds[31]
                                          : (!exp_du[21] && (exp_du != 22'd0));

    // timer RAM
    dtq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        valid_next        = valid_reg;
        insert_cnt_next   = insert_cnt_reg;
        slot_next         = slot_reg;
        scan_cnt_next     = scan_cnt_reg;
        rd_vld_next       = 1'b0;
        rd_idx_next       = scan_cnt_reg[IDX_W-1:0];
        best_found_next   = best_found_reg;
        best_idx_next     = best_idx_reg;
        best_next         = best_reg;
        pend_next         = pend_reg;
        pend_id_next      = pend_id_reg;
        fire_cnt_next     = fire_cnt_reg;
        resp_kind_next    = resp_kind_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_kind_next  = result_kind_reg;
        fired_id_next     = fired_id_reg;
        last_next         = last_reg;
        ram_we            = 1'b0;
        ram_waddr         = slot_reg;
        ram_wdata         = '{dl_sec: arm_sec, dl_usec: arm_usec, per_sec: add_s_reg,
                              per_usec: add_us_reg, id: id_reg, periodic: periodic_reg,
                              order: insert_cnt_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    slot_next       = '0;
                    scan_cnt_next   = '0;
                    best_found_next = 1'b0;
                    pend_next       = 1'b0;
                    fire_cnt_next   = '0;
                    state_next      = (operation == dtq_pkg::OP_RUN) ? ST_SCAN : ST_ADD_SCAN;
                end
            end

            // walk valid bits for the first free slot
            ST_ADD_SCAN:
            begin
                if (!valid_reg[slot_reg])
                begin
                    ram_we                = 1'b1;
                    valid_next[slot_reg]  = 1'b1;
                    insert_cnt_next       = insert_cnt_reg + 32'd1;
                    resp_kind_next        = dtq_pkg::KIND_ACCEPTED;
                    state_next            = ST_ADD_RESP;
                end
                else if (slot_reg == IDX_W'(CAPACITY - 1))
                begin
                    resp_kind_next = dtq_pkg::KIND_REJECTED;
                    state_next     = ST_ADD_RESP;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end

            ST_ADD_RESP:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_kind_next  = resp_kind_reg;
                    fired_id_next     = '0;
                    last_next         = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            // one RAM word per cycle through the comparator
            ST_SCAN:
            begin
                if (scan_cnt_reg != CNT_W'(CAPACITY))
                begin
                    rd_vld_next   = 1'b1;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
                if (rd_vld_reg && valid_reg[rd_idx_reg] && (!best_found_reg || cmp_before))
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = rd_idx_reg;
                    best_next       = ram_rdata;
                end
            end

            ST_CHECK:
            begin
                state_next = (best_found_reg && expired) ? ST_FIRE : ST_DONE;
            end

            // hold the fired id one round so the final one can carry last
            ST_FIRE:
            begin
                if (!pend_reg || out_free)
                begin
                    if (pend_reg)
                    begin
                        result_valid_next = 1'b1;
                        result_kind_next  = dtq_pkg::KIND_FIRED;
                        fired_id_next     = pend_id_reg;
                        last_next         = 1'b0;
                    end
                    pend_next     = 1'b1;
                    pend_id_next  = best_reg.id;
                    fire_cnt_next = fire_cnt_reg + 1'b1;
                    if (best_reg.periodic)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = best_idx_reg;
                        ram_wdata       = best_reg;
                        ram_wdata.dl_sec  = arm_sec;
                        ram_wdata.dl_usec = arm_usec;
                        ram_wdata.order   = insert_cnt_reg;
                        insert_cnt_next = insert_cnt_reg + 32'd1;
                    end
                    else
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                    end
                    scan_cnt_next   = '0;
                    best_found_next = 1'b0;
                    state_next      = (fire_cnt_reg == dtq_pkg::FIRE_CNT_W'(
                                       dtq_pkg::MAX_RESULTS - 1)) ? ST_DONE : ST_SCAN;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_kind_next  = pend_reg ? dtq_pkg::KIND_FIRED : dtq_pkg::KIND_NONE;
                    fired_id_next     = pend_reg ? pend_id_reg : '0;
                    last_next         = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            valid_reg        <= '0;
            insert_cnt_reg   <= '0;
            slot_reg         <= '0;
            scan_cnt_reg     <= '0;
            rd_vld_reg       <= 1'b0;
            best_found_reg   <= 1'b0;
            pend_reg         <= 1'b0;
            fire_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            insert_cnt_reg   <= insert_cnt_next;
            slot_reg         <= slot_next;
            scan_cnt_reg     <= scan_cnt_next;
            rd_vld_reg       <= rd_vld_next;
            best_found_reg   <= best_found_next;
            pend_reg         <= pend_next;
            fire_cnt_reg     <= fire_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= rd_idx_next;
        best_idx_reg    <= best_idx_next;
        best_reg        <= best_next;
        pend_id_reg     <= pend_id_next;
        resp_kind_reg   <= resp_kind_next;
        result_kind_reg <= result_kind_next;
        fired_id_reg    <= fired_id_next;
        last_reg        <= last_next;
        if (item_acc)
        begin
            op_reg       <= operation;
            now_s_reg    <= now_seconds;
            now_us_reg   <= now_microseconds;
            add_s_reg    <= clamp_s ? 32'd1 : add_seconds;
            add_us_reg   <= clamp_us ? dtq_pkg::USEC_MAX : add_microseconds[19:0];
            id_reg       <= timer_id;
            periodic_reg <= periodic;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_kind  = result_kind_reg;
    assign fired_id     = fired_id_reg;
    assign last         = last_reg;

    // checks
    `ASSERT_DIS(a_fire_cap, clk, rst_n,
        fire_cnt_reg <= dtq_pkg::FIRE_CNT_W'(dtq_pkg::MAX_RESULTS), "fired count overflow")
    `ASSERT_DIS(a_fire_has_best, clk, rst_n,
        (state_reg == ST_FIRE) |-> best_found_reg, "fire without a selected timer")
    `ASSERT_DIS(a_rd_in_scan, clk, rst_n,
        rd_vld_reg |-> (state_reg == ST_SCAN), "RAM read data outside a scan")
    `ASSERT_DIS(a_non_fired_last, clk, rst_n,
        (result_valid_reg && (result_kind_reg != dtq_pkg::KIND_FIRED)) |-> last_reg,
        "non-fired word without last")
    `ASSERT_DIS(a_add_op, clk, rst_n,
        (state_reg == ST_ADD_SCAN) |-> (op_reg == dtq_pkg::OP_ADD), "add search on a run word")

endmodule

`default_nettype wire

>>> tb/deadline_timer_queue_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deadline_timer_queue_core_tb
// Self-checking bench for the deadline timer queue core.
// ----------------------------------------------------------------------------
// Drives add and run words on the item channel and checks every result word
// against a cycle-free model of the timer store kept in a scoreboard class.
// A directed pass covers interval clamping, microsecond carry, ties, a full
// store and a sixteen-timer expiry; a random pass follows with a wandering
// clock, wrap-around jumps and random idling on both channels.
// ----------------------------------------------------------------------------

module deadline_timer_queue_core_tb;

    localparam int SLOTS        = 16;
    localparam int ONE_SEC_US   = 1000000;
    localparam int WORDS_PER_PH = 61;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] id;
        logic       final_word;
    } timer_answer_t;

    // Model of the timer store plus the queue of answers still owed
    class timer_expiry_board;
        logic          slot_used  [SLOTS];
        logic [31:0]   due_sec    [SLOTS];
        logic [19:0]   due_usec   [SLOTS];
        logic [31:0]   every_sec  [SLOTS];
        logic [19:0]   every_usec [SLOTS];
        logic [7:0]    owner_id   [SLOTS];
        logic          repeats    [SLOTS];
        logic [31:0]   seq_no     [SLOTS];
        logic [31:0]   next_seq;
        timer_answer_t answer_q[$];
        int            mismatches;

        function new();
            for (int k = 0; k < SLOTS; k++)
            begin
                slot_used[k] = 1'b0;
            end
            next_seq   = '0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return answer_q.size();
        endfunction

        // deadline = now + period, carry microseconds, fresh tie-break number
        function void rearm(int k, logic [31:0] ns, logic [19:0] nus);
            logic [31:0] s;
            logic [20:0] u;
            s = ns + every_sec[k];
            u = {1'b0, nus} + {1'b0, every_usec[k]};
            if (u >= dtq_pkg::USEC_PER_SEC)
            begin
                s = s + 32'd1;
                u = u - dtq_pkg::USEC_PER_SEC;
            end
            due_sec[k]  = s;
            due_usec[k] = u[19:0];
            seq_no[k]   = next_seq;
            next_seq    = next_seq + 32'd1;
        endfunction

        // earlier deadline wins; signed second difference, then usec, then age
        function bit fires_before(int a, int b);
            logic [31:0] ds;
            logic [31:0] dq;
            ds = due_sec[a] - due_sec[b];
            if (ds != 0)
                return ds[31];
            if (due_usec[a] != due_usec[b])
                return due_usec[a] < due_usec[b];
            dq = seq_no[a] - seq_no[b];
            return dq[31];
        endfunction

        // strictly before now, borrowing one second into the microseconds
        function bit is_due(int k, logic [31:0] ns, logic [19:0] nus);
            logic [31:0] d;
            int          now_u;
            int          due_u;
            int          du;
            d     = ns - due_sec[k];
            now_u = nus;
            due_u = due_usec[k];
            du    = now_u - due_u;
            if (du < 0)
            begin
                d  = d - 32'd1;
                du = du + ONE_SEC_US;
            end
            if (d != 0)
                return !d[31];
            return du > 0;
        endfunction

        function void predict_answers(logic op, logic [31:0] ns, logic [19:0] nus,
                                      logic [31:0] as, logic [31:0] aus,
                                      logic [7:0] id, logic per);
            logic [31:0]   s;
            logic [31:0]   u;
            int            slot;
            int            best;
            int            n;
            timer_answer_t a;
            if (op == dtq_pkg::OP_ADD)
            begin
                s = as;
                u = aus;
                if (u[31] || u >= dtq_pkg::USEC_PER_SEC)
                    u = {12'd0, dtq_pkg::USEC_MAX};
                if (s[31])
                    s = 32'd1;
                slot = -1;
                for (int k = 0; k < SLOTS; k++)
                begin
                    if (!slot_used[k] && slot < 0)
                        slot = k;
                end
                if (slot < 0)
                begin
                    a = '{dtq_pkg::KIND_REJECTED, 8'd0, 1'b1};
                end
                else
                begin
                    slot_used[slot]  = 1'b1;
                    every_sec[slot]  = s;
                    every_usec[slot] = u[19:0];
                    owner_id[slot]   = id;
                    repeats[slot]    = per;
                    rearm(slot, ns, nus);
                    a = '{dtq_pkg::KIND_ACCEPTED, 8'd0, 1'b1};
                end
                answer_q.push_back(a);
                return;
            end

            // run: fire the earliest due timer until none is due or the cap is hit
            n = 0;
            while (n < dtq_pkg::MAX_RESULTS)
            begin
                best = -1;
                for (int k = 0; k < SLOTS; k++)
                begin
                    if (slot_used[k] && (best < 0 || fires_before(k, best)))
                        best = k;
                end
                if (best < 0 || !is_due(best, ns, nus))
                    break;
                a = '{dtq_pkg::KIND_FIRED, owner_id[best], 1'b0};
                answer_q.push_back(a);
                n++;
                if (repeats[best])
                    rearm(best, ns, nus);
                else
                    slot_used[best] = 1'b0;
            end
            if (n == 0)
            begin
                a = '{dtq_pkg::KIND_NONE, 8'd0, 1'b1};
                answer_q.push_back(a);
            end
            else
            begin
                answer_q[answer_q.size() - 1].final_word = 1'b1;
            end
        endfunction

        function void check_answer(logic [1:0] kind, logic [7:0] id, logic lst);
            timer_answer_t e;
            if (answer_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result word: expected none, actual kind %0d id %0d last %0d",
                         $time, kind, id, lst);
                return;
            end
            e = answer_q.pop_front();
            if (kind !== e.kind)
            begin
                mismatches++;
                $display("%0t: result_kind expected %0d actual %0d", $time, e.kind, kind);
            end
            if (id !== e.id)
            begin
                mismatches++;
                $display("%0t: fired_id expected %0d actual %0d", $time, e.id, id);
            end
            if (lst !== e.final_word)
            begin
                mismatches++;
                $display("%0t: last expected %0d actual %0d", $time, e.final_word, lst);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_ready;
    logic               operation = dtq_pkg::OP_ADD;
    logic [31:0]        now_seconds = '0;
    logic [19:0]        now_microseconds = '0;
    logic signed [31:0] add_seconds = '0;
    logic signed [31:0] add_microseconds = '0;
    logic [7:0]         timer_id = '0;
    logic               periodic = 1'b0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [1:0]         result_kind;
    logic [7:0]         fired_id;
    logic               last;

    timer_expiry_board board = new();
    int                tx_idle = 35;
    int                rx_idle = 67;
    int                cycle_count = 0;
    logic [31:0]       cur_s = '0;
    int                cur_us = 0;

    deadline_timer_queue_core uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .operation        (operation),
        .now_seconds      (now_seconds),
        .now_microseconds (now_microseconds),
        .add_seconds      (add_seconds),
        .add_microseconds (add_microseconds),
        .timer_id         (timer_id),
        .periodic         (periodic),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .result_kind      (result_kind),
        .fired_id         (fired_id),
        .last             (last)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: check accepted words, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_answer(result_kind, fired_id, last);
        result_ready <= ($urandom_range(99) >= rx_idle);
    end

    // Present one word, hold it until accepted, then log it with the model
    task automatic send_word(input logic op, input logic [31:0] ns, input logic [19:0] nus,
                             input logic [31:0] as, input logic [31:0] aus,
                             input logic [7:0] id, input logic per);
        while ($urandom_range(99) < tx_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid       <= 1'b1;
        operation        <= op;
        now_seconds      <= ns;
        now_microseconds <= nus;
        add_seconds      <= as;
        add_microseconds <= aus;
        timer_id         <= id;
        periodic         <= per;
        do
            @(posedge clk);
        while (!item_ready);
        board.predict_answers(op, ns, nus, as, aus, id, per);
    endtask

    task automatic run_at(input logic [31:0] ns, input logic [19:0] nus);
        send_word(dtq_pkg::OP_RUN, ns, nus, $urandom, $urandom, 8'($urandom), 1'($urandom));
    endtask

    // One random word: move the clock, then add or run
    task automatic random_word();
        logic [31:0] as;
        logic [31:0] aus;
        logic [19:0] nus;
        int          r;
        r = $urandom_range(99);
        if (r < 3)
        begin
            cur_s  = $urandom;
            cur_us = $urandom_range(ONE_SEC_US - 1);
        end
        else if (r < 6)
        begin
            // quarter-wrap jump lets far deadlines come due
            cur_s = cur_s + 32'h4000_0000;
        end
        else if (r >= 16)
        begin
            cur_us = cur_us + $urandom_range(1500000);
            while (cur_us >= ONE_SEC_US)
            begin
                cur_us = cur_us - ONE_SEC_US;
                cur_s  = cur_s + 32'd1;
            end
        end
        // rare out-of-range microsecond part of now
        if ($urandom_range(99) < 3)
            nus = 20'($urandom_range(20'hFFFFF, ONE_SEC_US));
        else
            nus = 20'(cur_us);

        r = $urandom_range(99);
        if (r < 70)
            as = $urandom_range(3);
        else if (r < 80)
            as = $urandom_range(60);
        else if (r < 88)
            as = $urandom | 32'h8000_0000;
        else if (r < 95)
            as = $urandom;
        else
            as = 32'h7FFF_FFFF;

        r = $urandom_range(99);
        if (r < 75)
            aus = $urandom_range(ONE_SEC_US - 1);
        else if (r < 83)
            aus = ($urandom_range(1) != 0) ? 32'(dtq_pkg::USEC_MAX) : 32'd0;
        else if (r < 91)
            aus = $urandom_range(32'h7FFF_FFFF, ONE_SEC_US);
        else
            aus = $urandom | 32'h8000_0000;

        send_word(($urandom_range(99) < 55) ? dtq_pkg::OP_ADD : dtq_pkg::OP_RUN, cur_s, nus,
                  as, aus, 8'($urandom_range(255)), ($urandom_range(99) < 8));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store
        run_at(32'd0, 20'd0);
        // clamping: negative seconds, negative and huge microseconds
        send_word(dtq_pkg::OP_ADD, 32'd0, 20'd0, 32'h8000_0000, 32'h8000_0000, 8'hFF, 1'b0);
        send_word(dtq_pkg::OP_ADD, 32'd0, 20'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h00, 1'b0);
        // zero interval, microseconds just out of range, carry
        send_word(dtq_pkg::OP_ADD, 32'd5, 20'd0, 32'd0, 32'd0, 8'h01, 1'b0);
        send_word(dtq_pkg::OP_ADD, 32'd5, 20'd0, 32'd0, ONE_SEC_US, 8'h02, 1'b1);
        send_word(dtq_pkg::OP_ADD, 32'd5, 20'(ONE_SEC_US - 1), 32'd0,
                  32'(dtq_pkg::USEC_MAX), 8'h03, 1'b0);
        send_word(dtq_pkg::OP_ADD, 32'd5, 20'hFFFFF, 32'd0, 32'd0, 8'h04, 1'b0);
        // deadline equal to now does not fire; one microsecond later it does
        run_at(32'd5, 20'd0);
        run_at(32'd5, 20'd1);
        // several due, periodic one re-armed
        run_at(32'd7, 20'd0);
        // fill the store with tied deadlines, then one rejected add
        for (int k = 0; k < 15; k++)
            send_word(dtq_pkg::OP_ADD, 32'd7, 20'd0, 32'd1, 32'd0, 8'(8'h10 + k), 1'b0);
        // all sixteen due across the half-range boundary: hits the per-run cap
        run_at(32'h8000_0005, 20'd0);
        run_at(32'h8000_0005, 20'd0);

        cur_s  = 32'h8000_0005;
        cur_us = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle = (ph == 0) ? 35 : (ph == 1) ? 67 : 0;
            rx_idle = (ph == 0) ? 67 : (ph == 1) ? 35 : 0;
            for (int i = 0; i < WORDS_PER_PH; i++)
                random_word();
        end
        item_valid <= 1'b0;

        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
